FILE: hdl/psc_pkg.sv
// ----------------------------------------------------------------------------
// psc_pkg: shared definitions of the pressure-driven speed command
// Item types, action and mode codes, register indexes, thresholds and the
// state types of the sequencer and of the divide / square-root unit.
// ----------------------------------------------------------------------------
package psc_pkg;

  localparam int HISTORY_DEPTH_DEF = 8;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // Divider dividend width; the ratio dividend is the travel shifted up by 30.
  localparam int DIV_W       = 48;
  localparam int RATIO_SHIFT = 30;
  localparam int ROOT_STEPS  = 16;

  localparam logic [15:0] PULL_THRESHOLD = 16'd1311;
  localparam logic [15:0] PUSH_THRESHOLD = 16'd1967;
  localparam int          STEADY_BOUND   = 19660;
  localparam logic [15:0] ROOT_ONE       = 16'd32768;

  localparam logic [1:0] MODE_PRESSURE = 2'd0;
  localparam logic [1:0] MODE_GLOVE    = 2'd1;
  localparam logic [1:0] MODE_JOG      = 2'd2;

  localparam logic [2:0] ACT_SAMPLE       = 3'd0;
  localparam logic [2:0] ACT_CALIBRATE    = 3'd1;
  localparam logic [2:0] ACT_CAPTURE_LOW  = 3'd2;
  localparam logic [2:0] ACT_CAPTURE_HIGH = 3'd3;
  localparam logic [2:0] ACT_SET_LOW      = 3'd4;
  localparam logic [2:0] ACT_SET_HIGH     = 3'd5;

  localparam logic [CFG_INDEX_W-1:0] REG_CONTROL_MODE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DRIVE_LIMIT  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_JOG_LIMIT    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_GLOVE_MIN    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_GLOVE_MAX    = 3'd4;

  typedef struct packed {
    logic        [2:0]  action;
    logic        [15:0] pressure_a;
    logic        [15:0] pressure_b;
    logic signed [15:0] position;
    logic        [15:0] glove_reading;
    logic signed [15:0] limit_value;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] speed;
    logic               calibrated;
    logic               limits_valid;
  } out_item_t;

  typedef struct packed {
    logic shift;
    logic rotate;
    logic acc_clear;
    logic acc_en;
    logic capture;
    logic jog;
  } lane_ctrl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CAL,
    ST_CALCHK,
    ST_EVAL,
    ST_GMUL,
    ST_GDIV,
    ST_GWAIT,
    ST_GTGT,
    ST_RATIO,
    ST_SCALE,
    ST_DONE
  } psc_state_t;

  typedef enum logic [1:0] {
    U_IDLE,
    U_DIV,
    U_SQRT
  } psc_unit_t;

endpackage

FILE: hdl/psc_stream_if.sv
// ----------------------------------------------------------------------------
// psc_stream_if: valid/ready channel
// Carries one item of type T per transaction from source to sink.
// ----------------------------------------------------------------------------
interface psc_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/pressure_driven_speed_command.sv
// ----------------------------------------------------------------------------
// pressure_driven_speed_command: speed command from two pressure channels
// Top level: channel lanes, divide / square-root unit, sequencer and the
// output register.
// ----------------------------------------------------------------------------
// One item is in work at a time; a finished result waits in the output
// register while the next item is taken. A limit action or an undefined
// action goes straight to the done state; a sample in jog mode or in the
// undefined mode passes through evaluation first. A sample in pressure mode
// ends after evaluation when neither channel acts, passes through the scale
// state when the position ratio saturates, and otherwise uses the shared
// divider (48 quotient steps) and square root (16 steps). A sample in glove
// mode can take one multiply, one 48-step divide for the target, then the
// ratio as above. Offset calibration rotates the history line of each
// channel lane once to sum neighbor steps, then checks steadiness.
// A stalled output holds the item in work in the done state.
// ----------------------------------------------------------------------------
module pressure_driven_speed_command #(
  parameter int HISTORY_DEPTH = psc_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  psc_stream_if.sink                      in_ch,
  psc_stream_if.source                    out_ch,
  input  logic                            cfg_we,
  input  logic [psc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [psc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import psc_pkg::*;

  localparam int SumW = 16 + $clog2(HISTORY_DEPTH);
  localparam int CntW = $clog2(HISTORY_DEPTH);

  psc_state_t state, state_next;
  in_item_t   in_item;
  logic       in_acc;

  logic [1:0]  control_mode;
  logic [15:0] drive_limit;
  logic [15:0] jog_limit;
  logic [15:0] glove_min;
  logic [15:0] glove_max;

  logic signed [15:0] lower_limit;
  logic signed [15:0] upper_limit;
  logic signed [15:0] current_position;

  logic [CntW-1:0]    cnt;
  logic [15:0]        glove_r;
  logic signed [15:0] speed_r;
  logic               cal_r;
  logic               neg_r;
  logic [15:0]        mag_r;
  logic [15:0]        root_r;
  logic signed [33:0] prod_r;
  logic signed [35:0] target_r;

  logic       out_valid;
  out_item_t  out_data;

  lane_ctrl_t      ctrl_a, ctrl_b;
  logic [15:0]     lane_limit;
  logic [15:0]     lvl_a, lvl_b;
  logic [SumW-1:0] sum_a, sum_b;
  logic            steady;

  logic signed [16:0] span;
  logic signed [16:0] range_g;
  logic signed [16:0] gdiff;
  logic signed [16:0] pos17;
  logic               span_pos;
  logic               pull;
  logic               push;
  logic signed [16:0] p_num;
  logic signed [16:0] diff;
  logic signed [16:0] g_num;
  logic signed [16:0] ratio_num;
  logic               ratio_full;
  logic               between;
  logic               ratio_start;
  logic               gdiv_start;
  logic signed [15:0] jog_value;
  logic [33:0]        prod_mag;
  logic [15:0]        range_mag;
  logic signed [35:0] q_signed;
  logic signed [35:0] target_next;
  logic signed [35:0] lower36;
  logic signed [35:0] upper36;
  logic [15:0]        glove_cap;
  logic [31:0]        scaled;
  logic [15:0]        mag_next;

  logic             u_start;
  logic [DIV_W-1:0] u_dividend;
  logic [15:0]      u_divisor;
  logic             u_done;
  logic [DIV_W-1:0] u_quotient;
  logic [15:0]      u_root;

  assign in_item      = in_ch.data;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state == ST_IDLE);
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

  // Channel lanes.
  assign lane_limit = (control_mode == MODE_JOG) ? jog_limit : drive_limit;
  assign steady     = (sum_a <= SumW'(STEADY_BOUND)) && (sum_b <= SumW'(STEADY_BOUND));

  always_comb begin
    ctrl_a.shift     = in_acc && in_item.action == ACT_SAMPLE;
    ctrl_a.rotate    = (state == ST_CAL);
    ctrl_a.acc_clear = in_acc && in_item.action == ACT_CALIBRATE;
    ctrl_a.acc_en    = (state == ST_CAL) && cnt != CntW'(HISTORY_DEPTH - 1);
    ctrl_a.capture   = (state == ST_CALCHK) && steady;
    ctrl_a.jog       = (control_mode == MODE_JOG);
    ctrl_b           = ctrl_a;
  end

  psc_lane #(.Depth(HISTORY_DEPTH)) u_lane_a (
    .clk(clk), .rst(rst), .ctrl(ctrl_a), .sample(in_item.pressure_a),
    .limit(lane_limit), .level(lvl_a), .diff_sum(sum_a)
  );

  psc_lane #(.Depth(HISTORY_DEPTH)) u_lane_b (
    .clk(clk), .rst(rst), .ctrl(ctrl_b), .sample(in_item.pressure_b),
    .limit(lane_limit), .level(lvl_b), .diff_sum(sum_b)
  );

  // Merge of the lane results and the position geometry.
  assign span     = {upper_limit[15], upper_limit} - {lower_limit[15], lower_limit};
  assign range_g  = {1'b0, glove_max} - {1'b0, glove_min};
  assign gdiff    = {1'b0, glove_r} - {1'b0, glove_min};
  assign pos17    = {current_position[15], current_position};
  assign span_pos = span > 0;
  assign pull     = lvl_b >= PULL_THRESHOLD && current_position < upper_limit;
  assign push     = lvl_a >= PUSH_THRESHOLD && current_position > lower_limit;
  assign p_num    = pull ? {upper_limit[15], upper_limit} - pos17
                         : pos17 - {lower_limit[15], lower_limit};
  assign diff     = target_r[16:0] - pos17;
  assign g_num    = diff[16] ? -diff : diff;
  assign lower36  = 36'(lower_limit);
  assign upper36  = 36'(upper_limit);
  assign between  = target_r > lower36 && target_r < upper36;

  assign ratio_num  = (state == ST_GTGT) ? g_num : p_num;
  assign ratio_full = ratio_num >= span;

  always_comb begin
    jog_value = '0;
    if (lvl_a >= PUSH_THRESHOLD) jog_value = $signed({1'b0, lvl_a[15:1]});
    if (lvl_b >= PULL_THRESHOLD) jog_value = -$signed({1'b0, lvl_b[15:1]});
  end

  assign prod_mag    = prod_r[33] ? 34'(-prod_r) : 34'(prod_r);
  assign range_mag   = range_g[16] ? 16'(-range_g) : range_g[15:0];
  assign q_signed    = (prod_r[33] ^ range_g[16]) ? -$signed({2'b0, u_quotient[33:0]})
                                                  : $signed({2'b0, u_quotient[33:0]});
  assign target_next = upper36 - q_signed;

  assign glove_cap = drive_limit >> 1;
  assign scaled    = mag_r * root_r;
  assign mag_next  = (control_mode == MODE_GLOVE) ? ((root_r > glove_cap) ? glove_cap : root_r)
                                                 : scaled[31:16];

  // Shared divide / square-root unit.
  assign gdiv_start = (state == ST_GDIV);
  assign u_start    = ratio_start || gdiv_start;
  assign u_dividend = gdiv_start ? DIV_W'(prod_mag)
                                 : DIV_W'(ratio_num[15:0]) << RATIO_SHIFT;
  assign u_divisor  = gdiv_start ? range_mag : span[15:0];

  psc_divsqrt u_divsqrt (
    .clk(clk), .rst(rst), .start(u_start), .sqrt_en(ratio_start),
    .dividend(u_dividend), .divisor(u_divisor), .done(u_done),
    .quotient(u_quotient), .root(u_root)
  );

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_item.action)
            ACT_SAMPLE:    state_next = ST_EVAL;
            ACT_CALIBRATE: state_next = ST_CAL;
            default:       state_next = ST_DONE;
          endcase
        end
      end
      ST_CAL: if (cnt == CntW'(HISTORY_DEPTH - 1)) state_next = ST_CALCHK;
      ST_CALCHK: state_next = ST_DONE;
      ST_EVAL: begin
        unique case (control_mode)
          MODE_PRESSURE: begin
            if (!span_pos || !(pull || push)) state_next = ST_DONE;
            else if (ratio_full) state_next = ST_SCALE;
            else state_next = ST_RATIO;
          end
          MODE_GLOVE: begin
            if (!span_pos || range_g == 0) state_next = ST_DONE;
            else state_next = ST_GMUL;
          end
          default: state_next = ST_DONE;
        endcase
      end
      ST_GMUL: state_next = ST_GDIV;
      ST_GDIV: state_next = ST_GWAIT;
      ST_GWAIT: if (u_done) state_next = ST_GTGT;
      ST_GTGT: begin
        if (!between || diff == 0) state_next = ST_DONE;
        else if (ratio_full) state_next = ST_SCALE;
        else state_next = ST_RATIO;
      end
      ST_RATIO: if (u_done) state_next = ST_SCALE;
      ST_SCALE: state_next = ST_DONE;
      ST_DONE: if (!out_valid || out_ch.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ratio_start = 1'b0;
    unique case (state)
      ST_EVAL: ratio_start = control_mode == MODE_PRESSURE && span_pos && (pull || push)
                             && !ratio_full;
      ST_GTGT: ratio_start = between && diff != 0 && !ratio_full;
      default: ratio_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration and persistent state.
  always_ff @(posedge clk) begin
    if (rst) begin
      control_mode     <= MODE_PRESSURE;
      drive_limit      <= 16'hFFFF;
      jog_limit        <= 16'h8000;
      glove_min        <= '0;
      glove_max        <= 16'hFFFF;
      lower_limit      <= 16'sd16384;
      upper_limit      <= '0;
      current_position <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_CONTROL_MODE: control_mode <= cfg_data[1:0];
          REG_DRIVE_LIMIT:  drive_limit  <= cfg_data;
          REG_JOG_LIMIT:    jog_limit    <= cfg_data;
          REG_GLOVE_MIN:    glove_min    <= cfg_data;
          REG_GLOVE_MAX:    glove_max    <= cfg_data;
          default: ;
        endcase
      end
      if (in_acc) begin
        unique case (in_item.action)
          ACT_SAMPLE:       current_position <= in_item.position;
          ACT_CAPTURE_LOW:  lower_limit      <= current_position;
          ACT_CAPTURE_HIGH: upper_limit      <= current_position;
          ACT_SET_LOW:      lower_limit      <= in_item.limit_value;
          ACT_SET_HIGH:     upper_limit      <= in_item.limit_value;
          default: ;
        endcase
      end
    end
  end

  // Working registers of one transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      cal_r <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            speed_r <= '0;
            cal_r   <= 1'b0;
            cnt     <= '0;
            glove_r <= in_item.glove_reading;
          end
        end
        ST_CAL: cnt <= cnt + 1'b1;
        ST_CALCHK: if (steady) cal_r <= 1'b1;
        ST_EVAL: begin
          neg_r  <= pull;
          mag_r  <= pull ? lvl_b : lvl_a;
          root_r <= ROOT_ONE;
          if (control_mode == MODE_JOG) speed_r <= jog_value;
        end
        ST_GMUL: prod_r <= gdiff * span;
        ST_GWAIT: if (u_done) target_r <= target_next;
        ST_GTGT: begin
          neg_r  <= diff > 0;
          root_r <= ROOT_ONE;
        end
        ST_RATIO: if (u_done) root_r <= u_root;
        ST_SCALE: speed_r <= neg_r ? -$signed(mag_next) : $signed(mag_next);
        default: ;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && (!out_valid || out_ch.ready)) begin
      out_valid              <= 1'b1;
      out_data.speed         <= speed_r;
      out_data.calibrated    <= cal_r;
      out_data.limits_valid  <= upper_limit > lower_limit;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    in_acc |=> state != ST_IDLE)
    else $error("accepted transaction did not start work");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_CAL && cnt == CntW'(HISTORY_DEPTH - 1)) |=> state == ST_CALCHK)
    else $error("history rotation did not end after one full turn");

  assert property (@(posedge clk) disable iff (rst)
    ctrl_a.capture |=> cal_r)
    else $error("offset capture without calibrated flag");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCALE && !neg_r) |=> !speed_r[15])
    else $error("push speed came out negative");
endmodule

FILE: hdl/psc_lane.sv
// ----------------------------------------------------------------------------
// psc_lane: one pressure channel
// History line, offset, filtered level and the steadiness sum that is
// gathered one neighbor pair per cycle while the line rotates once.
// ----------------------------------------------------------------------------
module psc_lane #(
  parameter int  Depth = psc_pkg::HISTORY_DEPTH_DEF,
  localparam int SumW  = 16 + $clog2(Depth)
) (
  input  logic                clk,
  input  logic                rst,
  input  psc_pkg::lane_ctrl_t ctrl,
  input  logic [15:0]         sample,
  input  logic [15:0]         limit,
  output logic [15:0]         level,
  output logic [SumW-1:0]     diff_sum
);
  import psc_pkg::*;

  logic [15:0]     hist [Depth];
  logic [15:0]     offset;
  logic [SumW-1:0] acc;
  logic [19:0]     wsum;
  logic [17:0]     jsum;
  logic [15:0]     mean;
  logic [15:0]     above;
  logic [15:0]     absdiff;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < Depth; k++) hist[k] <= '0;
    end else if (ctrl.shift) begin
      hist[0] <= sample;
      for (int k = 1; k < Depth; k++) hist[k] <= hist[k-1];
    end else if (ctrl.rotate) begin
      for (int k = 0; k < Depth - 1; k++) hist[k] <= hist[k+1];
      hist[Depth-1] <= hist[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= '0;
      acc    <= '0;
    end else begin
      if (ctrl.capture) offset <= hist[0];
      if (ctrl.acc_clear) begin
        acc <= '0;
      end else if (ctrl.acc_en) begin
        acc <= acc + SumW'(absdiff);
      end
    end
  end

  assign absdiff = (hist[1] > hist[0]) ? hist[1] - hist[0] : hist[0] - hist[1];

  assign wsum = {1'b0, hist[0], 3'b0} + {2'b0, hist[1], 2'b0}
              + {3'b0, hist[2], 1'b0} + {4'b0, hist[3]};
  assign jsum = {2'b0, hist[0]} + {2'b0, hist[1]} + {2'b0, hist[2]} + {2'b0, hist[3]};

  always_comb begin
    mean  = ctrl.jog ? jsum[17:2] : wsum[19:4];
    above = (mean > offset) ? mean - offset : '0;
    level = (above > limit) ? limit : above;
  end

  assign diff_sum = acc;
endmodule

FILE: hdl/psc_divsqrt.sv
// ----------------------------------------------------------------------------
// psc_divsqrt: shared restoring divider and integer square root
// One quotient bit per cycle, then optionally one root bit per cycle on the
// low bits of the quotient.
// ----------------------------------------------------------------------------
module psc_divsqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      sqrt_en,
  input  logic [psc_pkg::DIV_W-1:0] dividend,
  input  logic [15:0]               divisor,
  output logic                      done,
  output logic [psc_pkg::DIV_W-1:0] quotient,
  output logic [15:0]               root
);
  import psc_pkg::*;

  localparam int CntW = $clog2(DIV_W);

  psc_unit_t        phase, phase_next;
  logic [CntW-1:0]  cnt;
  logic             chain;
  logic [DIV_W-1:0] quo;
  logic [15:0]      rem;
  logic [15:0]      dvs;
  logic [16:0]      trial;
  logic             ge;
  logic [DIV_W-1:0] quo_next;
  logic [30:0]      x;
  logic [30:0]      r;
  logic [30:0]      bitv;
  logic [30:0]      rb;

  assign trial    = {rem, quo[DIV_W-1]};
  assign ge       = trial >= {1'b0, dvs};
  assign quo_next = {quo[DIV_W-2:0], ge};
  assign rb       = r + bitv;

  always_comb begin
    phase_next = phase;
    unique case (phase)
      U_IDLE: if (start) phase_next = U_DIV;
      U_DIV: begin
        if (cnt == '0) phase_next = chain ? U_SQRT : U_IDLE;
      end
      U_SQRT: if (cnt == '0) phase_next = U_IDLE;
      default: phase_next = U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= U_IDLE;
      done  <= 1'b0;
    end else begin
      phase <= phase_next;
      done  <= (phase == U_DIV && cnt == '0 && !chain) || (phase == U_SQRT && cnt == '0);
    end
  end

  always_ff @(posedge clk) begin
    unique case (phase)
      U_IDLE: begin
        if (start) begin
          quo   <= dividend;
          rem   <= '0;
          dvs   <= divisor;
          chain <= sqrt_en;
          cnt   <= CntW'(DIV_W - 1);
        end
      end
      U_DIV: begin
        quo <= quo_next;
        rem <= ge ? 16'(trial - {1'b0, dvs}) : trial[15:0];
        if (cnt == '0) begin
          x    <= quo_next[30:0];
          r    <= '0;
          bitv <= 31'd1 << 30;
          cnt  <= CntW'(ROOT_STEPS - 1);
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
      U_SQRT: begin
        if (x >= rb) begin
          x <= x - rb;
          r <= (r >> 1) + bitv;
        end else begin
          r <= r >> 1;
        end
        bitv <= bitv >> 2;
        cnt  <= cnt - 1'b1;
      end
      default: ;
    endcase
  end

  assign quotient = quo;
  assign root     = r[15:0];
endmodule
